// File: design/rhm_pkg.sv
// ============================================================================
// rhm_pkg - shared types and constants for the Robin Hood hash map
// Slot geometry, action and status codes, datapath command and status types.
// ============================================================================
`default_nettype none

package rhm_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = 8;     // slot index bits
    localparam int LINK_W = 9;     // order link, all ones = no slot
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int PL_W   = 8;     // probe length bits
    localparam int CNT_W  = 9;

    localparam logic [LINK_W-1:0] NO_LINK       = '1;
    localparam logic [CNT_W-1:0]  MAX_ENT_RESET = 9'd192;
    localparam logic [31:0]       MIX_A         = 32'h21f0aaad;
    localparam logic [31:0]       MIX_B         = 32'h735a2d97;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_WALK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,    // latch the accepted item
        OP_WSET,    // point the slot address at the walk cursor
        OP_HOME,    // start a probe at the home slot
        OP_FCHK,    // find: check one slot
        OP_UPD,     // overwrite the value of the found slot
        OP_ICHK,    // insert: check one slot, place or swap
        OP_FIX1,    // link repair: links of a moved entry
        OP_FIX2,    // link repair: neighbors of a moved entry
        OP_APP1,    // append new entry: its own links
        OP_APP2,    // append new entry: old tail, head, count
        OP_DUNL,    // delete: unlink from insertion order
        OP_DCHK,    // delete: shift one entry back or stop
        OP_DLNK,    // delete: links of the shifted entry
        OP_RES      // load the result register
    } t_op;

    typedef enum logic [1:0] {
        RS_PLAIN,
        RS_LOOKUP,
        RS_WALK
    } t_res_sel;

    typedef struct packed {
        t_op      op;
        t_res_sel res_sel;
        t_status  res_stat;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    f_hit;
        logic    f_miss;
        logic    full;
        logic    i_done;
        logic    no_moves;
        logic    x_more;
        logic    d_stop;
        logic    out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: design/rhm_ctrl.sv
// ============================================================================
// rhm_ctrl - sequencer for the Robin Hood hash map
// Walks actions as needed: hash, probe, displacement, link repair, result.
// ============================================================================
`default_nettype none

module rhm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output rhm_pkg::t_cmd      o_cmd,
    input  wire rhm_pkg::t_stat i_stat
);
    import rhm_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_DISP  = 22'h000002,
        S_H2    = 22'h000004,
        S_HOME  = 22'h000008,
        S_FRD   = 22'h000010,
        S_FCK   = 22'h000020,
        S_UPD   = 22'h000040,
        S_IHOME = 22'h000080,
        S_IRD   = 22'h000100,
        S_ICK   = 22'h000200,
        S_XRD   = 22'h000400,
        S_XMT   = 22'h000800,
        S_XW1   = 22'h001000,
        S_XW2   = 22'h002000,
        S_AP1   = 22'h004000,
        S_AP2   = 22'h008000,
        S_DUNL  = 22'h010000,
        S_DRD   = 22'h020000,
        S_DCK   = 22'h040000,
        S_DLNK  = 22'h080000,
        S_WRD   = 22'h100000,
        S_RES   = 22'h200000
    } t_state;

    t_state   r_state,    n_state;
    t_res_sel r_res_sel,  n_res_sel;
    t_status  r_res_stat, n_res_stat;
    t_op      w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res_sel  <= RS_PLAIN;
            r_res_stat <= ST_MISS;
        end else begin
            r_state    <= n_state;
            r_res_sel  <= n_res_sel;
            r_res_stat <= n_res_stat;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res_sel  = r_res_sel;
        n_res_stat = r_res_stat;
        w_op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.action == ACT_WALK) begin
                    w_op    = OP_WSET;
                    n_state = S_WRD;
                end else begin
                    n_state = S_H2;
                end
            end
            S_H2:   n_state = S_HOME;
            S_HOME: begin
                w_op    = OP_HOME;
                n_state = S_FRD;
            end
            S_FRD:  n_state = S_FCK;
            S_FCK: begin
                w_op = OP_FCHK;
                if (i_stat.f_hit) begin
                    n_res_sel  = RS_PLAIN;
                    n_res_stat = ST_FOUND;
                    case (i_stat.action)
                        ACT_LOOKUP: begin
                            n_res_sel = RS_LOOKUP;
                            n_state   = S_RES;
                        end
                        ACT_INSERT: n_state = S_UPD;
                        ACT_DELETE: n_state = S_DUNL;
                        default:    n_state = S_RES;
                    endcase
                end else if (i_stat.f_miss) begin
                    n_res_sel = RS_PLAIN;
                    if (i_stat.action == ACT_INSERT && !i_stat.full) begin
                        n_state = S_IHOME;
                    end else if (i_stat.action == ACT_INSERT) begin
                        n_res_stat = ST_FULL;
                        n_state    = S_RES;
                    end else begin
                        n_res_stat = ST_MISS;
                        n_state    = S_RES;
                    end
                end else begin
                    n_state = S_FRD;
                end
            end
            S_UPD: begin
                w_op    = OP_UPD;
                n_state = S_RES;
            end
            S_IHOME: begin
                w_op    = OP_HOME;
                n_state = S_IRD;
            end
            S_IRD:  n_state = S_ICK;
            S_ICK: begin
                w_op = OP_ICHK;
                if (i_stat.i_done) begin
                    n_state = i_stat.no_moves ? S_AP1 : S_XRD;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_XRD:  n_state = S_XMT;
            S_XMT:  n_state = S_XW1;
            S_XW1: begin
                w_op    = OP_FIX1;
                n_state = S_XW2;
            end
            S_XW2: begin
                w_op    = OP_FIX2;
                n_state = i_stat.x_more ? S_XRD : S_AP1;
            end
            S_AP1: begin
                w_op    = OP_APP1;
                n_state = S_AP2;
            end
            S_AP2: begin
                w_op       = OP_APP2;
                n_res_sel  = RS_PLAIN;
                n_res_stat = ST_NEW;
                n_state    = S_RES;
            end
            S_DUNL: begin
                w_op    = OP_DUNL;
                n_state = S_DRD;
            end
            S_DRD:  n_state = S_DCK;
            S_DCK: begin
                w_op    = OP_DCHK;
                n_state = i_stat.d_stop ? S_RES : S_DLNK;
            end
            S_DLNK: begin
                w_op    = OP_DLNK;
                n_state = S_DRD;
            end
            S_WRD: begin
                n_res_sel = RS_WALK;
                n_state   = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    w_op    = OP_RES;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.op       = w_op;
    assign o_cmd.res_sel  = r_res_sel;
    assign o_cmd.res_stat = r_res_stat;

endmodule

`default_nettype wire

// File: design/rhm_datapath.sv
// ============================================================================
// rhm_datapath - slot storage, hash pipeline and link logic
// Slot memories, valid bits, move log, order head/tail, result register.
// ============================================================================
`default_nettype none

module rhm_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rhm_pkg::t_cmd i_cmd,
    output rhm_pkg::t_stat     o_stat,
    input  wire logic [79:0]   i_in_data,   // key, value, cursor
    input  wire logic [1:0]    i_in_user,   // action
    input  wire logic          i_cfg_wr_en,
    input  wire logic [8:0]    i_cfg_wr_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [95:0]        o_out_data,  // value, key, next, oldest, count
    output logic [1:0]         o_out_user   // status
);
    import rhm_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [PL_W-1:0]  pl;
    } t_ent;

    typedef struct packed {
        logic [SLOT_W-1:0] d;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] q;
    } t_logw;

    // memories
    t_ent              m_ent [SLOTS];
    logic [LINK_W-1:0] m_prv [SLOTS];
    logic [LINK_W-1:0] m_nxt [SLOTS];
    logic [SLOT_W-1:0] m_mt  [SLOTS];
    t_logw             m_log [SLOTS];

    // control state
    logic [SLOTS-1:0]  r_valid;
    logic [LINK_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0]  r_count, r_max;
    logic              r_oval;

    // payload
    t_action           r_act;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [LINK_W-1:0] r_cur;
    logic [31:0]       r_h1, r_h2;
    logic [SLOT_W-1:0] r_idx, r_dist, r_org, r_new, r_dst;
    logic [KEY_W-1:0]  r_ck;
    logic [VAL_W-1:0]  r_cv;
    logic [PL_W-1:0]   r_cd;
    logic [LINK_W-1:0] r_cp, r_cn, r_lp, r_lq;
    logic              r_isnew;
    logic [CNT_W-1:0]  r_nlog, r_j;
    logic [SLOTS-1:0]  r_touch;

    t_ent              r_rd_ent;
    logic [LINK_W-1:0] r_rd_prv, r_rd_nxt;
    t_logw             r_rd_log;
    logic [SLOT_W-1:0] r_mt_p, r_mt_q;
    logic              r_tp, r_tq;

    t_status           r_o_stat;
    logic [VAL_W-1:0]  r_o_val;
    logic [KEY_W-1:0]  r_o_key;
    logic [LINK_W-1:0] r_o_next, r_o_head;
    logic [CNT_W-1:0]  r_o_cnt;

    // write ports
    logic              ent_we, prv_we, nxt_we, mv_we;
    logic [SLOT_W-1:0] ent_wa, prv_wa, nxt_wa;
    t_ent              ent_wd;
    logic [LINK_W-1:0] prv_wd, nxt_wd;

    logic [31:0]       h_t1, h_t2, h_fin;
    logic [SLOT_W-1:0] home;
    logic              cur_valid, dist_gt, f_hit, f_miss, ins_place, d_stop;
    logic [CNT_W-1:0]  cap;
    logic [LINK_W-1:0] rp, rq, d_link;

    // hash mixer, one multiply per stage
    assign h_t1  = r_key ^ (r_key >> 16);
    assign h_t2  = r_h1 ^ (r_h1 >> 15);
    assign h_fin = r_h2 ^ (r_h2 >> 15);
    assign home  = h_fin[SLOT_W-1:0];

    assign cur_valid = r_valid[r_idx];
    assign dist_gt   = r_dist > r_rd_ent.pl;
    assign f_hit     = (r_count != '0) && cur_valid && !dist_gt && (r_rd_ent.key == r_key);
    assign f_miss    = !f_hit && ((r_count == '0) || !cur_valid || dist_gt ||
                                  (r_dist == SLOT_W'(SLOTS - 1)));
    assign ins_place = !cur_valid || (r_cd > r_rd_ent.pl);
    assign d_stop    = !cur_valid || (r_rd_ent.pl == '0);
    assign cap       = (r_max > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : r_max;

    // remap through the move table: a link to a slot whose entry moved follows it
    assign rp     = (!r_rd_log.p[LINK_W-1] && r_tp) ? {1'b0, r_mt_p} : r_rd_log.p;
    assign rq     = (!r_rd_log.q[LINK_W-1] && r_tq) ? {1'b0, r_mt_q} : r_rd_log.q;
    assign d_link = {1'b0, r_rd_log.d};

    assign mv_we = (i_cmd.op == OP_ICHK) && ins_place && !r_isnew;

    assign o_stat.action   = r_act;
    assign o_stat.f_hit    = f_hit;
    assign o_stat.f_miss   = f_miss;
    assign o_stat.full     = r_count >= cap;
    assign o_stat.i_done   = ins_place && !cur_valid;
    assign o_stat.no_moves = r_isnew;
    assign o_stat.x_more   = (r_j + 1'b1) != r_nlog;
    assign o_stat.d_stop   = d_stop;
    assign o_stat.out_free = !r_oval || i_out_ready;

    always_comb begin
        ent_we = 1'b0;  ent_wa = r_idx;  ent_wd = r_rd_ent;
        prv_we = 1'b0;  prv_wa = r_idx;  prv_wd = NO_LINK;
        nxt_we = 1'b0;  nxt_wa = r_idx;  nxt_wd = NO_LINK;
        case (i_cmd.op)
            OP_UPD: begin
                ent_we     = 1'b1;
                ent_wd.val = r_val;
            end
            OP_ICHK: begin
                if (ins_place) begin
                    ent_we = 1'b1;
                    ent_wd = '{key: r_ck, val: r_cv, pl: r_cd};
                    prv_we = 1'b1;
                    prv_wd = r_cp;
                    nxt_we = 1'b1;
                    nxt_wd = r_cn;
                end
            end
            OP_FIX1: begin
                prv_we = 1'b1;  prv_wa = r_rd_log.d;  prv_wd = rp;
                nxt_we = 1'b1;  nxt_wa = r_rd_log.d;  nxt_wd = rq;
            end
            OP_FIX2: begin
                nxt_we = !rp[LINK_W-1];  nxt_wa = rp[SLOT_W-1:0];  nxt_wd = d_link;
                prv_we = !rq[LINK_W-1];  prv_wa = rq[SLOT_W-1:0];  prv_wd = d_link;
            end
            OP_APP1: begin
                prv_we = 1'b1;  prv_wa = r_new;  prv_wd = r_tail;
                nxt_we = 1'b1;  nxt_wa = r_new;  nxt_wd = NO_LINK;
            end
            OP_APP2: begin
                nxt_we = !r_tail[LINK_W-1];
                nxt_wa = r_tail[SLOT_W-1:0];
                nxt_wd = {1'b0, r_new};
            end
            OP_DUNL: begin
                nxt_we = !r_rd_prv[LINK_W-1];  nxt_wa = r_rd_prv[SLOT_W-1:0];  nxt_wd = r_rd_nxt;
                prv_we = !r_rd_nxt[LINK_W-1];  prv_wa = r_rd_nxt[SLOT_W-1:0];  prv_wd = r_rd_prv;
            end
            OP_DCHK: begin
                if (!d_stop) begin
                    ent_we    = 1'b1;
                    ent_wa    = r_dst;
                    ent_wd.pl = PL_W'(r_rd_ent.pl - 1'b1);
                    nxt_we    = !r_rd_prv[LINK_W-1];
                    nxt_wa    = r_rd_prv[SLOT_W-1:0];
                    nxt_wd    = {1'b0, r_dst};
                    prv_we    = !r_rd_nxt[LINK_W-1];
                    prv_wa    = r_rd_nxt[SLOT_W-1:0];
                    prv_wd    = {1'b0, r_dst};
                end
            end
            OP_DLNK: begin
                prv_we = 1'b1;  prv_wa = r_dst;  prv_wd = r_lp;
                nxt_we = 1'b1;  nxt_wa = r_dst;  nxt_wd = r_lq;
            end
            default: ;
        endcase
    end

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        if (ent_we) m_ent[ent_wa] <= ent_wd;
        if (prv_we) m_prv[prv_wa] <= prv_wd;
        if (nxt_we) m_nxt[nxt_wa] <= nxt_wd;
        if (mv_we) begin
            m_mt[r_org]                <= r_idx;
            m_log[r_nlog[SLOT_W-1:0]] <= '{d: r_idx, p: r_cp, q: r_cn};
        end
        r_rd_ent <= m_ent[r_idx];
        r_rd_prv <= m_prv[r_idx];
        r_rd_nxt <= m_nxt[r_idx];
        r_rd_log <= m_log[r_j[SLOT_W-1:0]];
        r_mt_p   <= m_mt[r_rd_log.p[SLOT_W-1:0]];
        r_mt_q   <= m_mt[r_rd_log.q[SLOT_W-1:0]];
        r_tp     <= r_touch[r_rd_log.p[SLOT_W-1:0]];
        r_tq     <= r_touch[r_rd_log.q[SLOT_W-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= NO_LINK;
            r_tail  <= NO_LINK;
            r_count <= '0;
            r_max   <= MAX_ENT_RESET;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_max <= i_cfg_wr_data;
            if (i_cmd.op == OP_RES)  r_oval <= 1'b1;
            else if (i_out_ready)    r_oval <= 1'b0;
            case (i_cmd.op)
                OP_ICHK: begin
                    if (ins_place) r_valid[r_idx] <= 1'b1;
                end
                OP_FIX2: begin
                    if (rp[LINK_W-1]) r_head <= d_link;
                    if (rq[LINK_W-1]) r_tail <= d_link;
                end
                OP_APP2: begin
                    if (r_tail[LINK_W-1]) r_head <= {1'b0, r_new};
                    r_tail  <= {1'b0, r_new};
                    r_count <= r_count + 1'b1;
                end
                OP_DUNL: begin
                    if (r_rd_prv[LINK_W-1]) r_head <= r_rd_nxt;
                    if (r_rd_nxt[LINK_W-1]) r_tail <= r_rd_prv;
                    r_count <= r_count - 1'b1;
                end
                OP_DCHK: begin
                    if (d_stop) begin
                        r_valid[r_dst] <= 1'b0;
                    end else begin
                        if (r_rd_prv[LINK_W-1]) r_head <= {1'b0, r_dst};
                        if (r_rd_nxt[LINK_W-1]) r_tail <= {1'b0, r_dst};
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_h1 <= h_t1 * MIX_A;
        r_h2 <= h_t2 * MIX_B;
        case (i_cmd.op)
            OP_LOAD: begin
                r_act <= t_action'(i_in_user);
                r_key <= i_in_data[31:0];
                r_val <= i_in_data[63:32];
                r_cur <= i_in_data[72:64];
            end
            OP_WSET: r_idx <= r_cur[SLOT_W-1:0];
            OP_HOME: begin
                r_idx   <= home;
                r_dist  <= '0;
                r_ck    <= r_key;
                r_cv    <= r_val;
                r_cd    <= '0;
                r_cp    <= NO_LINK;
                r_cn    <= NO_LINK;
                r_isnew <= 1'b1;
                r_nlog  <= '0;
                r_j     <= '0;
                r_touch <= '0;
            end
            OP_FCHK: begin
                if (!f_hit && !f_miss) begin
                    r_idx  <= r_idx + 1'b1;
                    r_dist <= r_dist + 1'b1;
                end
            end
            OP_ICHK: begin
                r_idx <= r_idx + 1'b1;
                // evicted resident carries on one slot further from its home
                if (ins_place && cur_valid) r_cd <= PL_W'(r_rd_ent.pl + 1'b1);
                else                        r_cd <= r_cd + 1'b1;
                if (ins_place) begin
                    if (r_isnew) begin
                        r_new <= r_idx;
                    end else begin
                        r_touch[r_org] <= 1'b1;
                        r_nlog         <= r_nlog + 1'b1;
                    end
                    if (cur_valid) begin
                        // evicted resident becomes the carried entry
                        r_ck    <= r_rd_ent.key;
                        r_cv    <= r_rd_ent.val;
                        r_cp    <= r_rd_prv;
                        r_cn    <= r_rd_nxt;
                        r_org   <= r_idx;
                        r_isnew <= 1'b0;
                    end
                end
            end
            OP_FIX2: r_j <= r_j + 1'b1;
            OP_DUNL: begin
                r_dst <= r_idx;
                r_idx <= r_idx + 1'b1;
            end
            OP_DCHK: begin
                r_lp <= r_rd_prv;
                r_lq <= r_rd_nxt;
            end
            OP_DLNK: begin
                r_dst <= r_idx;
                r_idx <= r_idx + 1'b1;
            end
            OP_RES: begin
                r_o_head <= r_head;
                r_o_cnt  <= r_count;
                case (i_cmd.res_sel)
                    RS_LOOKUP: begin
                        r_o_stat <= ST_FOUND;
                        r_o_val  <= r_rd_ent.val;
                        r_o_key  <= '0;
                        r_o_next <= NO_LINK;
                    end
                    RS_WALK: begin
                        if (!r_cur[LINK_W-1] && cur_valid) begin
                            r_o_stat <= ST_FOUND;
                            r_o_val  <= r_rd_ent.val;
                            r_o_key  <= r_rd_ent.key;
                            r_o_next <= r_rd_nxt;
                        end else begin
                            r_o_stat <= ST_MISS;
                            r_o_val  <= '0;
                            r_o_key  <= '0;
                            r_o_next <= NO_LINK;
                        end
                    end
                    default: begin
                        r_o_stat <= i_cmd.res_stat;
                        r_o_val  <= '0;
                        r_o_key  <= '0;
                        r_o_next <= NO_LINK;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = {5'b0, r_o_cnt, r_o_head, r_o_next, r_o_key, r_o_val};
    assign o_out_user  = r_o_stat;

    // between items the live count matches the valid bits
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |-> ($countones(r_valid) == int'(r_count)))
        else $error("live count differs from valid bits");

    // empty order list exactly when nothing is live
    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |-> ((r_head[LINK_W-1] == (r_count == '0)) &&
                                   (r_tail[LINK_W-1] == r_head[LINK_W-1])))
        else $error("order head or tail inconsistent with count");

    // a new key is only appended while a slot is free
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_APP2) |-> (r_count < CNT_W'(SLOTS)))
        else $error("append into a full table");

endmodule

`default_nettype wire

// File: design/robin_hood_ordered_hash_map.sv
// ============================================================================
// robin_hood_ordered_hash_map - Robin Hood hash map with insertion order
// 256-slot linear-probing table on 32-bit keys with order links and walk.
// ============================================================================
// Usage:
//   s_axis carries one request item: tuser = action (lookup, insert/update,
//   delete, walk step), tdata = key, value, cursor. m_axis returns one result
//   item per request: tuser = status, tdata = value_out, key_out,
//   next_cursor, oldest_slot, live_count.
//   max_entries is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   must write it only while idle, and the block does not enforce this.
// Steps, one item at a time (entry and link memories have one read port each):
//   walk step: load, cursor, read, result. Lookup: load, hash, home, a read
//   and check per probed slot, result; update adds an overwrite. Insert
//   of a new key: the find, a restart at home, a read and place or swap per
//   displacement slot, link repair per displaced entry, then an append.
//   Delete: the find, an unlink, read/shift/relink per entry moved back, a stop.
// Reset: valid bits, order head/tail and count clear at once; no sweep.
//   max_entries returns to 192.
// Stall: the result sits in the output register; the next request is taken
//   and worked on meanwhile, and waits only to load its result.
// ============================================================================
`default_nettype none

module robin_hood_ordered_hash_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // key[31:0], value[63:32], cursor[72:64]
    input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // value_out[31:0], key_out[63:32],
                                            // next_cursor[72:64], oldest_slot[81:73],
                                            // live_count[90:82]
    output logic [1:0]       m_axis_tuser,  // status[1:0]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [8:0]  i_cfg_wr_data  // max_entries
);
    import rhm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one command per cycle to the datapath
    rhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // storage, hashing, link repair and the result register
    rhm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_user    (m_axis_tuser)
    );

endmodule

`default_nettype wire
